/* hw/rtl/pid_filtered_derivative_antiwindup_core_defines.svh */
// assertion macros used by the checker file
`ifndef PID_FILTERED_DERIVATIVE_ANTIWINDUP_CORE_DEFINES_SVH
`define PID_FILTERED_DERIVATIVE_ANTIWINDUP_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define PIDFD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pidfd: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define PIDFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pidfd: next-cycle check failed");

`endif

/* hw/rtl/pidfd_pkg.sv */
package pidfd_pkg;

  // datapath widths
  localparam int unsigned ERR_W     = 17;  // measured - target
  localparam int unsigned DT_W      = 16;  // elapsed milliseconds
  localparam int unsigned COEF_W    = 17;  // filter coefficient, up to 1.0 in Q0.16
  localparam int unsigned RAW_W     = 26;  // error slope and filtered slope, Q.8
  localparam int unsigned INTEG_W   = 48;  // integral accumulator
  localparam int unsigned MUL_A_W   = 18;
  localparam int unsigned MUL_B_W   = 27;
  localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;
  localparam int unsigned ACC_W     = 52;  // output sum in Q.16
  localparam int unsigned IH_W      = 40;  // gain_i times upper integral half
  localparam int unsigned ITERM_W   = 42;  // clamped integral term, Q.8
  localparam int unsigned Y_W       = ACC_W - 16;
  localparam int unsigned DRIVE_W   = 16;
  localparam int unsigned DIV_NUM_W = 25;  // widest dividend magnitude
  localparam int unsigned DIV_REM_W = 17;  // partial remainder, below the divisor
  localparam int unsigned DVS_W     = 17;  // widest divisor (filter_rc + dt)
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned CFG_W     = 31;
  localparam int unsigned CFG_IDX_W = 3;

  // divider step counts: quotient bits per division
  localparam logic [CNT_W-1:0] RAW_STEPS  = CNT_W'(DIV_NUM_W);
  localparam logic [CNT_W-1:0] COEF_STEPS = CNT_W'(COEF_W);

  // saturation limits
  localparam logic signed [INTEG_W-1:0] INTEG_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = 48'sh8000_0000_0000;
  localparam logic signed [63:0]        ITERM_MAX = 64'sh0000_0100_0000_0000;
  localparam logic signed [63:0]        ITERM_MIN = -64'sh0000_0100_0000_0000;
  localparam logic signed [Y_W-1:0]     DRIVE_MAX = 36'sd32767;
  localparam logic signed [Y_W-1:0]     DRIVE_MIN = -36'sd32768;
  localparam logic [ACC_W-1:0]          ROUND_HALF = 52'd32768;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P       = 3'd0,
    REG_GAIN_I       = 3'd1,
    REG_GAIN_D       = 3'd2,
    REG_WINDUP_LIMIT = 3'd3,
    REG_OUT_MIN      = 3'd4,
    REG_OUT_MAX      = 3'd5,
    REG_FILTER_RC    = 3'd6,
    REG_BOUND_ENABLE = 3'd7
  } cfg_idx_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_DIV_RAW,
    ST_DIV_COEF,
    ST_FILT,
    ST_DERIV,
    ST_INTEG,
    ST_KP,
    ST_KD,
    ST_KIH,
    ST_KIL,
    ST_ITERM,
    ST_SUM,
    ST_OUT
  } state_e;

endpackage

/* hw/rtl/pid_filtered_derivative_antiwindup_core.sv */
// PID controller with a low-pass filtered derivative and integral clamping.
// Each request carries measured, target and elapsed_ms; the block returns one
// drive value per request. On a normal step the next request can be accepted
// only after a bit-serial divider, which produces one quotient bit per cycle,
// has run two divisions in a row (25 bits
// for the error slope, 17 bits for the filter coefficient) and a single shared
// 18x27 multiplier has been used for six products. The first step after reset and any
// step with elapsed_ms of 0 skip the divisions. While a
// request is in progress s_axis_tready is low; a finished drive value waits in
// the output register and does not block the next request until that request
// itself completes. Configuration writes must only happen while idle.
module pid_filtered_derivative_antiwindup_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pidfd_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [pidfd_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [47:0]                     s_axis_tdata,  // measured, target, elapsed_ms
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [15:0]                     m_axis_tdata   // drive
);

  // configuration registers
  logic signed [15:0]               gain_p_q, gain_i_q, gain_d_q;
  logic [pidfd_pkg::CFG_W-1:0]      windup_limit_q;
  logic signed [15:0]               out_min_q, out_max_q;
  logic [15:0]                      filter_rc_q;
  logic                             bound_enable_q;

  // control state
  pidfd_pkg::state_e                       state_q, state_d;
  logic                                    first_q, first_d;
  logic signed [pidfd_pkg::ERR_W-1:0]      prev_err_q, prev_err_d;
  logic signed [pidfd_pkg::RAW_W-1:0]      prev_deriv_q, prev_deriv_d;
  logic signed [pidfd_pkg::INTEG_W-1:0]    integ_q, integ_d;
  logic                                    out_valid_q, out_valid_d;

  // working registers
  logic signed [pidfd_pkg::ERR_W-1:0]      err_q, err_d;
  logic [pidfd_pkg::DT_W-1:0]              dt_q, dt_d;
  logic signed [pidfd_pkg::RAW_W-1:0]      raw_q, raw_d;
  logic [pidfd_pkg::COEF_W-1:0]            coef_q, coef_d;
  logic signed [pidfd_pkg::RAW_W-1:0]      deriv_q, deriv_d;
  logic signed [pidfd_pkg::PROD_W-1:0]     prod_q;
  logic signed [pidfd_pkg::ACC_W-1:0]      acc_q, acc_d;
  logic signed [pidfd_pkg::IH_W-1:0]       ih_q, ih_d;
  logic signed [pidfd_pkg::ITERM_W-1:0]    iterm_q, iterm_d;
  logic signed [pidfd_pkg::Y_W-1:0]        y_q, y_d;
  logic [pidfd_pkg::DRIVE_W-1:0]           drive_q, drive_d;

  // divider registers
  logic [pidfd_pkg::DIV_NUM_W-1:0]         num_q, num_d;
  logic [pidfd_pkg::DIV_NUM_W-1:0]         quot_q, quot_d;
  logic [pidfd_pkg::DIV_REM_W-1:0]         rem_q, rem_d;
  logic [pidfd_pkg::DVS_W-1:0]             dvs_q, dvs_d;
  logic [pidfd_pkg::CNT_W-1:0]             cnt_q, cnt_d;
  logic                                    neg_q, neg_d;

  // shared multiplier
  logic signed [pidfd_pkg::MUL_A_W-1:0]    mul_a;
  logic signed [pidfd_pkg::MUL_B_W-1:0]    mul_b;
  logic signed [pidfd_pkg::PROD_W-1:0]     mul_p;

  // combinational helpers
  logic signed [pidfd_pkg::ERR_W-1:0]      err_in;
  logic signed [pidfd_pkg::ERR_W:0]        err_diff, err_neg;
  logic [pidfd_pkg::ERR_W-1:0]             err_mag;
  logic [pidfd_pkg::DIV_REM_W:0]           rem_sh, rem_nx;
  logic                                    div_ge;
  logic [pidfd_pkg::DIV_NUM_W-1:0]         quot_nx;
  logic [pidfd_pkg::RAW_W-1:0]             raw_mag;
  logic signed [pidfd_pkg::MUL_B_W-1:0]    filt_diff;
  logic signed [pidfd_pkg::INTEG_W:0]      isum;
  logic signed [pidfd_pkg::INTEG_W-1:0]    integ_sat;
  logic signed [63:0]                      ifull;
  logic signed [pidfd_pkg::ITERM_W-1:0]    iterm_c;
  logic signed [pidfd_pkg::ACC_W-1:0]      acc_sum;
  logic signed [pidfd_pkg::Y_W-1:0]        lo_ext, hi_ext, y_lo, y_bnd, y_sat;
  logic signed [pidfd_pkg::INTEG_W-1:0]    lim_pos, lim_neg, integ_clip;
  logic                                    s_acc, out_free;

  // handshake
  assign s_axis_tready = (state_q == pidfd_pkg::ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = drive_q;
  assign out_free      = !out_valid_q || m_axis_tready;

  // error of the incoming request
  assign err_in = $signed({s_axis_tdata[15], s_axis_tdata[15:0]})
                - $signed({s_axis_tdata[31], s_axis_tdata[31:16]});

  // error change and its magnitude for the slope division
  assign err_diff = $signed({err_q[pidfd_pkg::ERR_W-1], err_q})
                  - $signed({prev_err_q[pidfd_pkg::ERR_W-1], prev_err_q});
  assign err_neg  = -err_diff;
  assign err_mag  = err_diff[pidfd_pkg::ERR_W] ? err_neg[pidfd_pkg::ERR_W-1:0]
                                               : err_diff[pidfd_pkg::ERR_W-1:0];

  // restoring divider, one quotient bit per cycle
  assign rem_sh  = {rem_q, num_q[pidfd_pkg::DIV_NUM_W-1]};
  assign div_ge  = rem_sh >= {1'b0, dvs_q};
  assign rem_nx  = div_ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
  assign quot_nx = {quot_q[pidfd_pkg::DIV_NUM_W-2:0], div_ge};
  assign raw_mag = {1'b0, quot_nx};

  // filter input: raw slope minus previous filtered slope
  assign filt_diff = $signed({raw_q[pidfd_pkg::RAW_W-1], raw_q})
                   - $signed({prev_deriv_q[pidfd_pkg::RAW_W-1], prev_deriv_q});

  // integral growth with 48-bit saturation
  assign isum = $signed({integ_q[pidfd_pkg::INTEG_W-1], integ_q})
              + $signed({{15{prod_q[33]}}, prod_q[33:0]});
  assign integ_sat = (isum[pidfd_pkg::INTEG_W] != isum[pidfd_pkg::INTEG_W-1])
                   ? (isum[pidfd_pkg::INTEG_W] ? pidfd_pkg::INTEG_MIN : pidfd_pkg::INTEG_MAX)
                   : isum[pidfd_pkg::INTEG_W-1:0];

  // integral term from two partial products, clamped
  assign ifull = $signed({ih_q, 24'b0}) + $signed({{23{prod_q[40]}}, prod_q[40:0]});
  always_comb begin
    priority if (ifull > pidfd_pkg::ITERM_MAX) begin
      iterm_c = pidfd_pkg::ITERM_MAX[pidfd_pkg::ITERM_W-1:0];
    end else if (ifull < pidfd_pkg::ITERM_MIN) begin
      iterm_c = pidfd_pkg::ITERM_MIN[pidfd_pkg::ITERM_W-1:0];
    end else begin
      iterm_c = ifull[pidfd_pkg::ITERM_W-1:0];
    end
  end

  // final sum with round-half-up
  assign acc_sum = acc_q
                 + $signed({{2{iterm_q[pidfd_pkg::ITERM_W-1]}}, iterm_q, 8'b0})
                 + $signed(pidfd_pkg::ROUND_HALF);

  // output bounding or saturation
  assign lo_ext = $signed({{20{out_min_q[15]}}, out_min_q});
  assign hi_ext = $signed({{20{out_max_q[15]}}, out_max_q});
  assign y_lo   = (y_q < lo_ext) ? lo_ext : y_q;
  assign y_bnd  = (y_lo > hi_ext) ? hi_ext : y_lo;
  always_comb begin
    priority if (y_q > pidfd_pkg::DRIVE_MAX) begin
      y_sat = pidfd_pkg::DRIVE_MAX;
    end else if (y_q < pidfd_pkg::DRIVE_MIN) begin
      y_sat = pidfd_pkg::DRIVE_MIN;
    end else begin
      y_sat = y_q;
    end
  end

  // anti-windup clamp of the integral
  assign lim_pos = $signed({17'b0, windup_limit_q});
  assign lim_neg = -lim_pos;
  always_comb begin
    priority if (integ_q > lim_pos) begin
      integ_clip = lim_pos;
    end else if (integ_q < lim_neg) begin
      integ_clip = lim_neg;
    end else begin
      integ_clip = integ_q;
    end
  end

  // shared multiplier
  assign mul_p = mul_a * mul_b;

  // sequencer: next state, datapath loads and multiplier operands
  always_comb begin
    state_d      = state_q;
    first_d      = first_q;
    prev_err_d   = prev_err_q;
    prev_deriv_d = prev_deriv_q;
    integ_d      = integ_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    err_d        = err_q;
    dt_d         = dt_q;
    raw_d        = raw_q;
    coef_d       = coef_q;
    deriv_d      = deriv_q;
    acc_d        = acc_q;
    ih_d         = ih_q;
    iterm_d      = iterm_q;
    y_d          = y_q;
    drive_d      = drive_q;
    num_d        = num_q;
    quot_d       = quot_q;
    rem_d        = rem_q;
    dvs_d        = dvs_q;
    cnt_d        = cnt_q;
    neg_d        = neg_q;
    mul_a        = '0;
    mul_b        = '0;

    unique case (state_q)
      pidfd_pkg::ST_IDLE: begin
        if (s_acc) begin
          err_d   = err_in;
          dt_d    = s_axis_tdata[47:32];
          state_d = pidfd_pkg::ST_START;
        end
      end

      // choose between the full update and the held-slope path
      pidfd_pkg::ST_START: begin
        if (first_q) begin
          deriv_d = '0;
          state_d = pidfd_pkg::ST_KP;
        end else if (dt_q == '0) begin
          deriv_d = prev_deriv_q;
          state_d = pidfd_pkg::ST_KP;
        end else begin
          neg_d   = err_diff[pidfd_pkg::ERR_W];
          num_d   = {err_mag, 8'b0};
          rem_d   = '0;
          quot_d  = '0;
          dvs_d   = {1'b0, dt_q};
          cnt_d   = pidfd_pkg::RAW_STEPS;
          state_d = pidfd_pkg::ST_DIV_RAW;
        end
      end

      // slope = error change * 256 / dt, truncated toward zero
      pidfd_pkg::ST_DIV_RAW: begin
        num_d  = num_q << 1;
        rem_d  = rem_nx[pidfd_pkg::DIV_REM_W-1:0];
        quot_d = quot_nx;
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == 1'b1) begin
          raw_d   = neg_q ? $signed(-raw_mag) : $signed(raw_mag);
          // coefficient dividend dt * 65536: high part preloads the remainder
          num_d   = {dt_q[0], 24'b0};
          rem_d   = {2'b0, dt_q[15:1]};
          quot_d  = '0;
          dvs_d   = {1'b0, filter_rc_q} + {1'b0, dt_q};
          cnt_d   = pidfd_pkg::COEF_STEPS;
          state_d = pidfd_pkg::ST_DIV_COEF;
        end
      end

      // coefficient = dt * 65536 / (filter_rc + dt)
      pidfd_pkg::ST_DIV_COEF: begin
        num_d  = num_q << 1;
        rem_d  = rem_nx[pidfd_pkg::DIV_REM_W-1:0];
        quot_d = quot_nx;
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == 1'b1) begin
          coef_d  = quot_nx[pidfd_pkg::COEF_W-1:0];
          state_d = pidfd_pkg::ST_FILT;
        end
      end

      pidfd_pkg::ST_FILT: begin
        mul_a   = $signed({1'b0, coef_q});
        mul_b   = filt_diff;
        state_d = pidfd_pkg::ST_DERIV;
      end

      // filtered slope, floor of the Q0.16 product; issue err * dt
      pidfd_pkg::ST_DERIV: begin
        deriv_d = prev_deriv_q + $signed(prod_q[pidfd_pkg::RAW_W+15:16]);
        mul_a   = $signed({2'b0, dt_q});
        mul_b   = $signed({{10{err_q[pidfd_pkg::ERR_W-1]}}, err_q});
        state_d = pidfd_pkg::ST_INTEG;
      end

      pidfd_pkg::ST_INTEG: begin
        integ_d = integ_sat;
        state_d = pidfd_pkg::ST_KP;
      end

      pidfd_pkg::ST_KP: begin
        mul_a   = $signed({{2{gain_p_q[15]}}, gain_p_q});
        mul_b   = $signed({{10{err_q[pidfd_pkg::ERR_W-1]}}, err_q});
        state_d = pidfd_pkg::ST_KD;
      end

      // proportional term into Q.16, issue derivative product
      pidfd_pkg::ST_KD: begin
        acc_d   = $signed({prod_q[pidfd_pkg::ACC_W-9:0], 8'b0});
        mul_a   = $signed({{2{gain_d_q[15]}}, gain_d_q});
        mul_b   = $signed({deriv_q[pidfd_pkg::RAW_W-1], deriv_q});
        state_d = pidfd_pkg::ST_KIH;
      end

      // add derivative term, issue gain_i times upper integral half
      pidfd_pkg::ST_KIH: begin
        acc_d   = acc_q + $signed({{(pidfd_pkg::ACC_W-pidfd_pkg::PROD_W){
                                    prod_q[pidfd_pkg::PROD_W-1]}}, prod_q});
        mul_a   = $signed({{2{gain_i_q[15]}}, gain_i_q});
        mul_b   = $signed({{3{integ_q[pidfd_pkg::INTEG_W-1]}}, integ_q[47:24]});
        state_d = pidfd_pkg::ST_KIL;
      end

      // keep upper partial product, issue lower half (unsigned)
      pidfd_pkg::ST_KIL: begin
        ih_d    = prod_q[pidfd_pkg::IH_W-1:0];
        mul_a   = $signed({{2{gain_i_q[15]}}, gain_i_q});
        mul_b   = $signed({3'b0, integ_q[23:0]});
        state_d = pidfd_pkg::ST_ITERM;
      end

      pidfd_pkg::ST_ITERM: begin
        iterm_d = iterm_c;
        state_d = pidfd_pkg::ST_SUM;
      end

      pidfd_pkg::ST_SUM: begin
        y_d     = acc_sum[pidfd_pkg::ACC_W-1:16];
        state_d = pidfd_pkg::ST_OUT;
      end

      // deliver once the output register is free, then commit state
      pidfd_pkg::ST_OUT: begin
        if (out_free) begin
          drive_d      = bound_enable_q ? y_bnd[pidfd_pkg::DRIVE_W-1:0]
                                        : y_sat[pidfd_pkg::DRIVE_W-1:0];
          out_valid_d  = 1'b1;
          prev_err_d   = err_q;
          prev_deriv_d = deriv_q;
          first_d      = 1'b0;
          if (bound_enable_q) begin
            integ_d = integ_clip;
          end
          state_d      = pidfd_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = pidfd_pkg::ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pidfd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // controller state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q      <= 1'b1;
      prev_err_q   <= '0;
      prev_deriv_q <= '0;
      integ_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      first_q      <= first_d;
      prev_err_q   <= prev_err_d;
      prev_deriv_q <= prev_deriv_d;
      integ_q      <= integ_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    err_q   <= err_d;
    dt_q    <= dt_d;
    raw_q   <= raw_d;
    coef_q  <= coef_d;
    deriv_q <= deriv_d;
    prod_q  <= mul_p;
    acc_q   <= acc_d;
    ih_q    <= ih_d;
    iterm_q <= iterm_d;
    y_q     <= y_d;
    drive_q <= drive_d;
    num_q   <= num_d;
    quot_q  <= quot_d;
    rem_q   <= rem_d;
    dvs_q   <= dvs_d;
    cnt_q   <= cnt_d;
    neg_q   <= neg_d;
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q       <= '0;
      gain_i_q       <= '0;
      gain_d_q       <= '0;
      windup_limit_q <= '0;
      out_min_q      <= '0;
      out_max_q      <= '0;
      filter_rc_q    <= '0;
      bound_enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        pidfd_pkg::REG_GAIN_P:       gain_p_q       <= cfg_data_i[15:0];
        pidfd_pkg::REG_GAIN_I:       gain_i_q       <= cfg_data_i[15:0];
        pidfd_pkg::REG_GAIN_D:       gain_d_q       <= cfg_data_i[15:0];
        pidfd_pkg::REG_WINDUP_LIMIT: windup_limit_q <= cfg_data_i;
        pidfd_pkg::REG_OUT_MIN:      out_min_q      <= cfg_data_i[15:0];
        pidfd_pkg::REG_OUT_MAX:      out_max_q      <= cfg_data_i[15:0];
        pidfd_pkg::REG_FILTER_RC:    filter_rc_q    <= cfg_data_i[15:0];
        pidfd_pkg::REG_BOUND_ENABLE: bound_enable_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

endmodule

/* hw/rtl/pidfd_checker.sv */
`include "pid_filtered_derivative_antiwindup_core_defines.svh"

// port-level checks on the controller's stream behavior
module pidfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  logic s_acc;
  logic m_stall;

  assign s_acc   = s_axis_tvalid && s_axis_tready;
  assign m_stall = m_axis_tvalid && !m_axis_tready;

  // one request at a time: busy right after an accepted request
  `PIDFD_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, s_acc, !s_axis_tready)

  // a result never appears in the cycle right after acceptance
  `PIDFD_ASSERT_NEXT(a_no_instant_result, clk_i, rst_ni, s_acc, !$rose(m_axis_tvalid))

  // a new result is only produced while the input side is busy
  `PIDFD_ASSERT_SAME(a_result_while_busy, clk_i, rst_ni, $rose(m_axis_tvalid), $past(!s_axis_tready))

  // stalled result holds
  `PIDFD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_stall, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind pid_filtered_derivative_antiwindup_core pidfd_checker u_pidfd_checker (.*);

/* verif/pid_filtered_derivative_antiwindup_core_tb.sv */
module pid_filtered_derivative_antiwindup_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 64;   // one slow step plus margin
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned PHASE_ITEMS  = 250;

  localparam longint ITERM_CAP = longint'(1) << 40;
  localparam longint ACC_HI    = (longint'(1) << 47) - 1;
  localparam longint ACC_LO    = -(longint'(1) << 47);

  logic                            clk_i;
  logic                            rst_ni        = 1'b0;
  logic                            cfg_we_i      = 1'b0;
  logic [pidfd_pkg::CFG_IDX_W-1:0] cfg_addr_i    = '0;
  logic [pidfd_pkg::CFG_W-1:0]     cfg_data_i    = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [47:0]                     s_axis_tdata  = '0;  // measured, target, elapsed_ms
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [15:0]                     m_axis_tdata;        // drive

  pid_filtered_derivative_antiwindup_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // directed plan rows: register write or control step
  typedef enum logic {ROW_WRITE, ROW_STEP} row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    pidfd_pkg::cfg_idx_e idx;
    logic [30:0]         val;
    logic signed [15:0]  meas;
    logic signed [15:0]  tgt;
    logic [15:0]         dt;
    logic                typed;   // drive below is the expected value
    logic signed [15:0]  drive;
  } plan_row_t;

  localparam int unsigned PLAN_ROWS = 42;

  plan_row_t dir_plan [PLAN_ROWS] = '{
    // pure proportional, unity gain: drive equals the saturated error
    '{ROW_WRITE, pidfd_pkg::REG_GAIN_P, 31'd256, 16'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0},
    '{ROW_STEP, pidfd_pkg::REG_GAIN_P, 31'd0, 16'sd100, 16'sd40, 16'd5000, 1'b1, 16'sd60},
    '{ROW_STEP, pidfd_pkg::REG_GAIN_P, 31'd0, 16'sh7FFF, 16'sh8000, 16'hFFFF, 1'b1, 16'sh7FFF},
    '{ROW_STEP, pidfd_pkg::REG_GAIN_P, 31'd0, 16'sh8000, 16'sh7FFF, 16'd1, 1'b1, 16'sh8000},
    '{ROW_STEP, pidfd_pkg::REG_GAIN_P, 31'd0, 16'sd0, 16'sd0, 16'd0, 1'b1, 16'sd0},
    '{ROW_STEP, pidfd_pkg::REG_GAIN_P, 31'd0, -16'sd1, 16'sd0, 16'd0, 1'b1, -16'sd1},
    '{ROW_STEP, pidfd_pkg::REG_GAIN_P, 31'd0, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 1'b1, 16'sd0},
    '{ROW_STEP, pidfd_pkg::REG_GAIN_P, 31'd0, 16'sd12345, -16'sd100, 16'd7, 1'b1, 16'sd12445},
    // extreme gains, bounding on, unfiltered derivative
    '{ROW_WRITE, pidfd_pkg::REG_GAIN_P, 31'h0000_8000, 16'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0},
    '{ROW_WRITE, pidfd_pkg::REG_GAIN_I, 31'd1, 16'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0},
    '{ROW_WRITE, pidfd_pkg::REG_GAIN_D, 31'h0000_7FFF, 16'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0},
    '{ROW_WRITE, pidfd_pkg::REG_WINDUP_LIMIT, 31'h7FFF_FFFF, 16'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0},
    '{ROW_WRITE, pidfd_pkg::REG_OUT_MIN, 31'h0000_FC18, 16'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0},
    '{ROW_WRITE, pidfd_pkg::REG_OUT_MAX, 31'd1000, 16'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0},
    '{ROW_WRITE, pidfd_pkg::REG_FILTER_RC, 31'd0, 16'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0},
    '{ROW_WRITE, pidfd_pkg::REG_BOUND_ENABLE, 31'd1, 16'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0},
    '{ROW_STEP, pidfd_pkg::REG_GAIN_P, 31'd0, 16'sd10, 16'sd0, 16'd3, 1'b0, 16'sd0},
    '{ROW_STEP, pidfd_pkg::REG_GAIN_P, 31'd0, 16'sd5, 16'sd3, 16'd0, 1'b0, 16'sd0},
    '{ROW_STEP, pidfd_pkg::REG_GAIN_P, 31'd0, -16'sd7, 16'sd20, 16'hFFFF, 1'b0, 16'sd0},
    '{ROW_STEP, pidfd_pkg::REG_GAIN_P, 31'd0, 16'sh7FFF, 16'sh8000, 16'd1, 1'b0, 16'sd0},
    '{ROW_STEP, pidfd_pkg::REG_GAIN_P, 31'd0, 16'sd0, 16'sd1, 16'd2, 1'b0, 16'sd0},
    // inverted bounds, slowest filter, zero windup limit
    '{ROW_WRITE, pidfd_pkg::REG_OUT_MIN, 31'd500, 16'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0},
    '{ROW_WRITE, pidfd_pkg::REG_OUT_MAX, 31'h0000_FE0C, 16'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0},
    '{ROW_WRITE, pidfd_pkg::REG_FILTER_RC, 31'h0000_FFFF, 16'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0},
    '{ROW_WRITE, pidfd_pkg::REG_GAIN_I, 31'h0000_8000, 16'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0},
    '{ROW_WRITE, pidfd_pkg::REG_WINDUP_LIMIT, 31'd0, 16'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0},
    '{ROW_WRITE, pidfd_pkg::REG_GAIN_P, 31'd3, 16'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0},
    '{ROW_STEP, pidfd_pkg::REG_GAIN_P, 31'd0, 16'sd3, 16'sd1, 16'd2, 1'b0, 16'sd0},
    '{ROW_STEP, pidfd_pkg::REG_GAIN_P, 31'd0, 16'sh8000, 16'sh7FFF, 16'hFFFF, 1'b0, 16'sd0},
    '{ROW_STEP, pidfd_pkg::REG_GAIN_P, 31'd0, 16'sd40, -16'sd40, 16'd9, 1'b0, 16'sd0},
    // unbounded: integral term runs into its saturation
    '{ROW_WRITE, pidfd_pkg::REG_BOUND_ENABLE, 31'd0, 16'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0},
    '{ROW_WRITE, pidfd_pkg::REG_GAIN_D, 31'd0, 16'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0},
    '{ROW_WRITE, pidfd_pkg::REG_WINDUP_LIMIT, 31'd12345, 16'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0},
    '{ROW_STEP, pidfd_pkg::REG_GAIN_P, 31'd0, 16'sh7FFF, 16'sh8000, 16'hFFFF, 1'b0, 16'sd0},
    '{ROW_STEP, pidfd_pkg::REG_GAIN_P, 31'd0, 16'sh7FFF, 16'sh8000, 16'hFFFF, 1'b0, 16'sd0},
    '{ROW_STEP, pidfd_pkg::REG_GAIN_P, 31'd0, 16'sd0, 16'sd0, 16'd1, 1'b0, 16'sd0},
    '{ROW_STEP, pidfd_pkg::REG_GAIN_P, 31'd0, 16'sd1, 16'sd0, 16'd0, 1'b0, 16'sd0},
    // positive integral gain on the saturated sum
    '{ROW_WRITE, pidfd_pkg::REG_GAIN_I, 31'h0000_7FFF, 16'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0},
    '{ROW_STEP, pidfd_pkg::REG_GAIN_P, 31'd0, -16'sd2, 16'sd2, 16'd4, 1'b0, 16'sd0},
    '{ROW_STEP, pidfd_pkg::REG_GAIN_P, 31'd0, 16'sh8000, 16'sd0, 16'd300, 1'b0, 16'sd0},
    '{ROW_STEP, pidfd_pkg::REG_GAIN_P, 31'd0, 16'sd0, 16'sh7FFF, 16'd300, 1'b0, 16'sd0},
    '{ROW_STEP, pidfd_pkg::REG_GAIN_P, 31'd0, 16'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0}
  };

  // register mirror
  logic signed [15:0] gain_p_q, gain_i_q, gain_d_q, out_lo, out_hi;
  logic [30:0]        windup_lim;
  logic [15:0]        rc_ms;
  logic               bound_en;

  // controller state mirror
  logic   first_pending = 1'b1;
  longint last_err      = 0;
  longint last_slope    = 0;
  longint err_integral  = 0;

  logic signed [15:0] expected_drive [$];
  int unsigned        mismatches   = 0;
  int unsigned        cycle_count  = 0;
  bit                 bursty       = 1'b1;
  bit                 hold_off_req = 1'b0;
  int                 setpoint_base = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  // one control step on the mirrored state
  function automatic logic signed [15:0] step_controller(logic signed [15:0] meas,
                                                         logic signed [15:0] tgt,
                                                         logic [15:0] dt);
    longint err, slope, coef, filt, iterm, acc, y, dtl;
    dtl  = longint'(dt);
    err  = longint'(meas) - longint'(tgt);
    filt = 0;
    if (!first_pending) begin
      if (dtl != 0) begin
        slope        = ((err - last_err) * 256) / dtl;
        coef         = (dtl * 65536) / (longint'(rc_ms) + dtl);
        filt         = last_slope + ((coef * (slope - last_slope)) >>> 16);
        err_integral = clip(err_integral + err * dtl, ACC_LO, ACC_HI);
      end else begin
        filt = last_slope;
      end
    end
    iterm = clip(longint'(gain_i_q) * err_integral, -ITERM_CAP, ITERM_CAP);
    acc   = longint'(gain_p_q) * err * 256 + longint'(gain_d_q) * filt + iterm * 256;
    y     = (acc + 32768) >>> 16;
    last_err   = err;
    last_slope = filt;
    if (bound_en) begin
      if (y < longint'(out_lo)) y = longint'(out_lo);
      if (y > longint'(out_hi)) y = longint'(out_hi);
      err_integral = clip(err_integral, -longint'(windup_lim), longint'(windup_lim));
    end else begin
      y = clip(y, -32768, 32767);
    end
    first_pending = 1'b0;
    return y[15:0];
  endfunction

  // register write, leaves the write enable high for a following write
  task automatic write_reg(pidfd_pkg::cfg_idx_e idx, logic [30:0] val);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    case (idx)
      pidfd_pkg::REG_GAIN_P:       gain_p_q   = val[15:0];
      pidfd_pkg::REG_GAIN_I:       gain_i_q   = val[15:0];
      pidfd_pkg::REG_GAIN_D:       gain_d_q   = val[15:0];
      pidfd_pkg::REG_WINDUP_LIMIT: windup_lim = val;
      pidfd_pkg::REG_OUT_MIN:      out_lo     = val[15:0];
      pidfd_pkg::REG_OUT_MAX:      out_hi     = val[15:0];
      pidfd_pkg::REG_FILTER_RC:    rc_ms      = val[15:0];
      pidfd_pkg::REG_BOUND_ENABLE: bound_en   = val[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // offer one request and record its expected drive once accepted
  task automatic push_request(logic signed [15:0] meas, logic signed [15:0] tgt,
                              logic [15:0] dt, logic typed, logic signed [15:0] drive);
    logic signed [15:0] predicted;
    cfg_we_i <= 1'b0;
    if (bursty && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {dt, tgt, meas};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = step_controller(meas, tgt, dt);
    expected_drive.push_back(typed ? drive : predicted);
  endtask

  // drop valid, wait for every drive value, then let the block go idle
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_drive.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_gain(int unsigned span);
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3, 4:    return 16'($urandom);
      default: return 16'(int'($urandom_range(0, 2 * span)) - int'(span));
    endcase
  endfunction

  function automatic logic [15:0] pick_dt();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 2) return 16'd0;
    if (sel < 10) return 16'($urandom_range(1, 20));
    if (sel < 16) return 16'($urandom_range(1, 1000));
    if (sel < 19) return 16'($urandom);
    return 16'hFFFF;
  endfunction

  function automatic logic signed [15:0] pick_extreme();
    case ($urandom_range(0, 3))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sd0;
      default: return -16'sd1;
    endcase
  endfunction

  function automatic logic signed [15:0] sat16(int v);
    return 16'(clip(longint'(v), -32768, 32767));
  endfunction

  task automatic random_config();
    logic [15:0] lo, hi, tmp;
    logic [30:0] lim;
    write_reg(pidfd_pkg::REG_GAIN_P, 31'(pick_gain(512)));
    write_reg(pidfd_pkg::REG_GAIN_I, 31'(pick_gain(16)));
    write_reg(pidfd_pkg::REG_GAIN_D, 31'(pick_gain(512)));
    case ($urandom_range(0, 3))
      0:       lim = 31'd0;
      1:       lim = 31'h7FFF_FFFF;
      2:       lim = 31'($urandom_range(0, 100000));
      default: lim = 31'($urandom);
    endcase
    write_reg(pidfd_pkg::REG_WINDUP_LIMIT, lim);
    lo = ($urandom_range(0, 4) == 0) ? 16'h8000 : 16'($urandom);
    hi = ($urandom_range(0, 4) == 0) ? 16'h7FFF : 16'($urandom);
    // mostly ordered bounds, sometimes inverted
    if ($signed(lo) > $signed(hi) && $urandom_range(0, 9) < 7) begin
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end
    write_reg(pidfd_pkg::REG_OUT_MIN, 31'(lo));
    write_reg(pidfd_pkg::REG_OUT_MAX, 31'(hi));
    case ($urandom_range(0, 3))
      0:       write_reg(pidfd_pkg::REG_FILTER_RC, 31'd0);
      1:       write_reg(pidfd_pkg::REG_FILTER_RC, 31'h0000_FFFF);
      2:       write_reg(pidfd_pkg::REG_FILTER_RC, 31'($urandom_range(0, 100)));
      default: write_reg(pidfd_pkg::REG_FILTER_RC, 31'($urandom_range(0, 65535)));
    endcase
    write_reg(pidfd_pkg::REG_BOUND_ENABLE, 31'($urandom_range(0, 1)));
  endtask

  // one random item: mostly a loop tracking a setpoint, some noise and extremes
  task automatic random_request();
    int          sel, tgt_v;
    logic [15:0] dt;
    sel = $urandom_range(0, 19);
    dt  = pick_dt();
    if (sel < 12) begin
      tgt_v = setpoint_base + int'($urandom_range(0, 40)) - 20;
      push_request(sat16(tgt_v + int'($urandom_range(0, 600)) - 300), sat16(tgt_v), dt,
                   1'b0, 16'sd0);
    end else if (sel < 17) begin
      push_request(16'($urandom), 16'($urandom), dt, 1'b0, 16'sd0);
    end else begin
      push_request(pick_extreme(), pick_extreme(), dt, 1'b0, 16'sd0);
    end
  endtask

  // result side: check each accepted drive, then choose next ready
  initial begin
    int unsigned        stall_left;
    logic signed [15:0] want;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (expected_drive.size() == 0) begin
          $error("drive: unexpected result %0d", $signed(m_axis_tdata));
          mismatches++;
        end else begin
          want = expected_drive.pop_front();
          if (m_axis_tdata !== want) begin
            $error("drive: expected %0d, actual %0d", want, $signed(m_axis_tdata));
            mismatches++;
          end
        end
      end
      if (hold_off_req) begin
        stall_left   = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (bursty && $urandom_range(0, 7) == 0) begin
        stall_left    = $urandom_range(0, 8);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // main sequence
  initial begin
    gain_p_q   = '0;
    gain_i_q   = '0;
    gain_d_q   = '0;
    windup_lim = '0;
    out_lo     = '0;
    out_hi     = '0;
    rc_ms      = '0;
    bound_en   = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed plan
    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (dir_plan[r].kind == ROW_WRITE) begin
        if (r > 0 && dir_plan[r-1].kind == ROW_STEP) settle();
        write_reg(dir_plan[r].idx, dir_plan[r].val);
      end else begin
        push_request(dir_plan[r].meas, dir_plan[r].tgt, dir_plan[r].dt,
                     dir_plan[r].typed, dir_plan[r].drive);
      end
    end

    // random phases, each with its own register setting
    for (int p = 0; p < PHASES; p++) begin
      settle();
      random_config();
      setpoint_base = int'($urandom_range(0, 40000)) - 20000;
      bursty        = (p != PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 1 && n == PHASE_ITEMS / 4) hold_off_req = 1'b1;
        random_request();
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
